@@ sv/mi3_pkg.sv @@
// ----------------------------------------------------------------------------
// mi3_pkg
// types and constants shared by the 3x3 matrix inverse pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  localparam int NumEnt   = 9;
  localparam int InW      = 16;
  localparam int CofW     = 33;
  localparam int DetW     = 49;
  localparam int MagW     = 32;
  localparam int DivW     = 48;
  localparam int QW       = 32;
  localparam int FracSh   = 24;
  localparam int DivSteps = QW;

  // operand indexes of the two products of each cofactor: x*y - z*w
  localparam int IdxX [NumEnt] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int IdxY [NumEnt] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int IdxZ [NumEnt] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int IdxW [NumEnt] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [QW-1:0]   lo;
    logic [QW-1:0]   q;
    logic            neg;
    logic            ovf;
  } lane_t;

  typedef struct packed {
    lane_t [NumEnt-1:0] lane;
    logic [DivW-1:0]    dm;
    logic               singular;
  } div_t;

endpackage

`default_nettype wire

@@ sv/mi3_front.sv @@
// ----------------------------------------------------------------------------
// mi3_front
// five-stage front end: products, cofactors, determinant, divider setup
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [mi3_pkg::InW-1:0] ent [mi3_pkg::NumEnt],
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output mi3_pkg::div_t                     out_data
);

  localparam int NS = 5;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  logic signed [31:0]               pa [mi3_pkg::NumEnt];
  logic signed [31:0]               pb [mi3_pkg::NumEnt];
  logic signed [mi3_pkg::InW-1:0]   r0a [3];
  logic signed [mi3_pkg::InW-1:0]   r0b [3];
  logic signed [mi3_pkg::CofW-1:0]  cofb [mi3_pkg::NumEnt];
  logic signed [mi3_pkg::CofW-1:0]  cofc [mi3_pkg::NumEnt];
  logic signed [mi3_pkg::DetW-1:0]  t [3];
  logic signed [mi3_pkg::DetW-1:0]  det;
  logic [mi3_pkg::MagW-1:0]         cmag [mi3_pkg::NumEnt];
  logic [mi3_pkg::NumEnt-1:0]       csgn;
  logic signed [mi3_pkg::DetW+1:0]  dsum;
  logic signed [mi3_pkg::DetW-1:0]  dneg;
  logic signed [mi3_pkg::CofW-1:0]  cneg [mi3_pkg::NumEnt];
  logic [mi3_pkg::DivW-1:0]         dmag;

  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  always_comb begin
    rdy[NS] = out_ready;
    for (int s = 0; s < NS; s++) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (rdy[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  always_comb begin
    dsum = (mi3_pkg::DetW+2)'(t[0]) + (mi3_pkg::DetW+2)'(t[1])
         + (mi3_pkg::DetW+2)'(t[2]);
    dneg = -det;
    dmag = det[mi3_pkg::DetW-1] ? dneg[mi3_pkg::DivW-1:0] : det[mi3_pkg::DivW-1:0];
    for (int k = 0; k < mi3_pkg::NumEnt; k++) begin
      cneg[k] = -cofc[k];
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < mi3_pkg::NumEnt; k++) begin
        pa[k] <= 32'(ent[mi3_pkg::IdxX[k]]) * 32'(ent[mi3_pkg::IdxY[k]]);
        pb[k] <= 32'(ent[mi3_pkg::IdxZ[k]]) * 32'(ent[mi3_pkg::IdxW[k]]);
      end
      for (int j = 0; j < 3; j++) begin
        r0a[j] <= ent[j];
      end
    end
  end

  // cofactors
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int k = 0; k < mi3_pkg::NumEnt; k++) begin
        cofb[k] <= mi3_pkg::CofW'(pa[k]) - mi3_pkg::CofW'(pb[k]);
      end
      r0b <= r0a;
    end
  end

  // determinant terms along row 0
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      t[0] <= mi3_pkg::DetW'(r0b[0]) * mi3_pkg::DetW'(cofb[0]);
      t[1] <= mi3_pkg::DetW'(r0b[1]) * mi3_pkg::DetW'(cofb[3]);
      t[2] <= mi3_pkg::DetW'(r0b[2]) * mi3_pkg::DetW'(cofb[6]);
      cofc <= cofb;
    end
  end

  // determinant sum, cofactor magnitudes
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      det <= dsum[mi3_pkg::DetW-1:0];
      for (int k = 0; k < mi3_pkg::NumEnt; k++) begin
        csgn[k] <= cofc[k][mi3_pkg::CofW-1];
        cmag[k] <= cofc[k][mi3_pkg::CofW-1] ? cneg[k][mi3_pkg::MagW-1:0]
                                            : cofc[k][mi3_pkg::MagW-1:0];
      end
    end
  end

  // divider setup
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      out_data.dm       <= dmag;
      out_data.singular <= (det == '0);
      for (int k = 0; k < mi3_pkg::NumEnt; k++) begin
        out_data.lane[k].neg <= csgn[k] ^ det[mi3_pkg::DetW-1];
        out_data.lane[k].ovf <= {24'd0, cmag[k]} >= {dmag, 8'd0};
        out_data.lane[k].rem <= mi3_pkg::DivW'(cmag[k][mi3_pkg::MagW-1:8]);
        out_data.lane[k].lo  <= {cmag[k][7:0], 24'd0};
        out_data.lane[k].q   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/mi3_div_step.sv @@
// ----------------------------------------------------------------------------
// mi3_div_step
// one restoring division step for all nine lanes, one register stage
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div_step (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mi3_pkg::div_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mi3_pkg::div_t      out_data
);

  logic                  v;
  mi3_pkg::div_t         nxt;
  logic [mi3_pkg::DivW:0]   r2 [mi3_pkg::NumEnt];
  logic [mi3_pkg::DivW+1:0] diff [mi3_pkg::NumEnt];

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  always_comb begin
    nxt = in_data;
    for (int k = 0; k < mi3_pkg::NumEnt; k++) begin
      r2[k]   = {in_data.lane[k].rem, in_data.lane[k].lo[mi3_pkg::QW-1]};
      diff[k] = {1'b0, r2[k]} - {2'b00, in_data.dm};
      nxt.lane[k].lo = {in_data.lane[k].lo[mi3_pkg::QW-2:0], 1'b0};
      if (!diff[k][mi3_pkg::DivW+1]) begin
        nxt.lane[k].rem = diff[k][mi3_pkg::DivW-1:0];
        nxt.lane[k].q   = {in_data.lane[k].q[mi3_pkg::QW-2:0], 1'b1};
      end else begin
        nxt.lane[k].rem = r2[k][mi3_pkg::DivW-1:0];
        nxt.lane[k].q   = {in_data.lane[k].q[mi3_pkg::QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/mi3_sat.sv @@
// ----------------------------------------------------------------------------
// mi3_sat
// output register: sign, saturation and singular masking
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_sat (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mi3_pkg::div_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [mi3_pkg::QW-1:0] inv [mi3_pkg::NumEnt],
  output logic               singular
);

  localparam logic [mi3_pkg::QW-1:0] NegMax = {1'b1, {(mi3_pkg::QW-1){1'b0}}};
  localparam logic [mi3_pkg::QW-1:0] PosMax = {1'b0, {(mi3_pkg::QW-1){1'b1}}};

  logic                  v;
  logic [mi3_pkg::QW-1:0] res [mi3_pkg::NumEnt];

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  always_comb begin
    for (int k = 0; k < mi3_pkg::NumEnt; k++) begin
      if (in_data.singular) begin
        res[k] = '0;
      end else if (in_data.lane[k].neg) begin
        res[k] = (in_data.lane[k].ovf || in_data.lane[k].q > NegMax) ? NegMax
                                                                    : -in_data.lane[k].q;
      end else begin
        res[k] = (in_data.lane[k].ovf || in_data.lane[k].q[mi3_pkg::QW-1]) ? PosMax
                                                                          : in_data.lane[k].q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      inv      <= res;
      singular <= in_data.singular;
    end
  end

endmodule

`default_nettype wire

@@ sv/matrix3x3_inverse.sv @@
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 matrix inverse by adjugate, Q8.8 in, saturated Q16.16 out
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  input    item_valid / item_ready   m00 .. m22 (signed Q8.8)
//  output   res_valid / res_ready     inv00 .. inv22 (signed Q16.16), singular
//
//  one item per cycle while the output is not stalled; 5 front stages, 32 division steps
//  (one quotient bit per stage), one output register
//  each stage holds its item while stalled and fills bubbles ahead of it
//  rst clears every stage valid bit; payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3x3_inverse (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic signed [15:0] m00,
  input  wire logic signed [15:0] m01,
  input  wire logic signed [15:0] m02,
  input  wire logic signed [15:0] m10,
  input  wire logic signed [15:0] m11,
  input  wire logic signed [15:0] m12,
  input  wire logic signed [15:0] m20,
  input  wire logic signed [15:0] m21,
  input  wire logic signed [15:0] m22,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic signed [31:0] inv00,
  output logic signed [31:0] inv01,
  output logic signed [31:0] inv02,
  output logic signed [31:0] inv10,
  output logic signed [31:0] inv11,
  output logic signed [31:0] inv12,
  output logic signed [31:0] inv20,
  output logic signed [31:0] inv21,
  output logic signed [31:0] inv22,
  output logic             singular
);

  localparam int NStep = mi3_pkg::DivSteps;

  logic signed [mi3_pkg::InW-1:0] ent [mi3_pkg::NumEnt];
  mi3_pkg::div_t                  dd [NStep+1];
  logic [NStep:0]                 dv;
  logic [NStep:0]                 dr;
  logic [mi3_pkg::QW-1:0]         inv [mi3_pkg::NumEnt];

  assign ent[0] = m00;
  assign ent[1] = m01;
  assign ent[2] = m02;
  assign ent[3] = m10;
  assign ent[4] = m11;
  assign ent[5] = m12;
  assign ent[6] = m20;
  assign ent[7] = m21;
  assign ent[8] = m22;

  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .ent       (ent),
    .out_valid (dv[0]),
    .out_ready (dr[0]),
    .out_data  (dd[0])
  );

  for (genvar s = 0; s < NStep; s++) begin : g_div
    mi3_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[s]),
      .in_ready  (dr[s]),
      .in_data   (dd[s]),
      .out_valid (dv[s+1]),
      .out_ready (dr[s+1]),
      .out_data  (dd[s+1])
    );
  end

  mi3_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv[NStep]),
    .in_ready  (dr[NStep]),
    .in_data   (dd[NStep]),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .inv       (inv),
    .singular  (singular)
  );

  assign inv00 = inv[0];
  assign inv01 = inv[1];
  assign inv02 = inv[2];
  assign inv10 = inv[3];
  assign inv11 = inv[4];
  assign inv12 = inv[5];
  assign inv20 = inv[6];
  assign inv21 = inv[7];
  assign inv22 = inv[8];

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && singular |-> inv00 == 0 && inv11 == 0 && inv22 == 0 && inv01 == 0
      && inv02 == 0 && inv10 == 0 && inv12 == 0 && inv20 == 0 && inv21 == 0)
    else $error("singular item with nonzero entries");
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> item_ready)
    else $error("pipeline stalls with output ready");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
  a_div_flow: assert property (@(posedge clk) disable iff (rst)
    dv[NStep] && dr[NStep] |=> res_valid)
    else $error("item lost at output register");
`endif

endmodule

`default_nettype wire

@@ sim/mi3_checker.sv @@
// ----------------------------------------------------------------------------
// mi3_checker
// watches both channels of the 3x3 matrix inverse, predicts each inverse
// from the accepted matrix by exact adjugate arithmetic, compares in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module mi3_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire logic        item_ready,
  input  wire logic signed [15:0] m [9],
  input  wire logic        res_valid,
  input  wire logic        res_ready,
  input  wire logic signed [31:0] inv [9],
  input  wire logic        singular,
  output int               errors,
  output int               pending
);

  typedef struct {
    logic signed [31:0] ent [9];
    logic               sing;
  } inverse_t;

  inverse_t inv_q [$];

  function automatic logic signed [31:0] sat_quot(longint c, longint d);
    logic        neg;
    logic [63:0] cm, dm, q;
    neg = (c < 0) != (d < 0);
    cm = (c < 0) ? -c : c;
    dm = (d < 0) ? -d : d;
    q = (cm << 24) / dm;
    if (c == 0) return 0;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return 32'(q);
  endfunction

  function automatic inverse_t predict_inverse(logic signed [15:0] e [9]);
    longint   a [3][3];
    longint   cof [9];
    longint   det;
    inverse_t r;
    for (int i = 0; i < 9; i++) a[i/3][i%3] = e[i];
    det = a[0][0]*a[1][1]*a[2][2] + a[0][1]*a[1][2]*a[2][0]
        + a[0][2]*a[1][0]*a[2][1] - a[0][2]*a[1][1]*a[2][0]
        - a[0][0]*a[1][2]*a[2][1] - a[0][1]*a[1][0]*a[2][2];
    cof[0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
    cof[1] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
    cof[2] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
    cof[3] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
    cof[4] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
    cof[5] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
    cof[6] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
    cof[7] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
    cof[8] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
    for (int i = 0; i < 9; i++) r.ent[i] = (det == 0) ? 0 : sat_quot(cof[i], det);
    r.sing = (det == 0);
    return r;
  endfunction

  assign pending = inv_q.size();

  always @(posedge clk) begin
    inverse_t x;
    int       nerr;
    nerr = 0;
    if (rst) begin
      errors <= 0;
    end else begin
      if (item_valid && item_ready) inv_q.push_back(predict_inverse(m));
      if (res_valid && res_ready) begin
        if (inv_q.size() == 0) begin
          $error("result with no matrix outstanding");
          nerr++;
        end else begin
          x = inv_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (inv[i] !== x.ent[i]) begin
              $error("inv%0d%0d expected %0d actual %0d", i/3, i%3, x.ent[i], inv[i]);
              nerr++;
            end
          if (singular !== x.sing) begin
            $error("singular expected %0d actual %0d", x.sing, singular);
            nerr++;
          end
        end
      end
      errors <= errors + nerr;
    end
  end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// streams directed and random Q8.8 matrices through the inverse with random
// gaps and output stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_ready;
  logic signed [15:0] m [9];
  logic res_valid;
  logic res_ready = 0;
  logic signed [31:0] inv [9];
  logic singular;
  int   errors, pending;
  bit   hold_out = 0;

  initial for (int i = 0; i < 9; i++) m[i] = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  matrix3x3_inverse u_dut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready),
    .m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]), .m12(m[5]),
    .m20(m[6]), .m21(m[7]), .m22(m[8]),
    .res_valid(res_valid), .res_ready(res_ready),
    .inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]), .inv10(inv[3]),
    .inv11(inv[4]), .inv12(inv[5]), .inv20(inv[6]), .inv21(inv[7]),
    .inv22(inv[8]), .singular(singular)
  );

  mi3_checker u_check (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready),
    .m(m), .res_valid(res_valid), .res_ready(res_ready), .inv(inv),
    .singular(singular), .errors(errors), .pending(pending)
  );

  task automatic send_matrix(logic signed [15:0] e [9], int gap);
    repeat (gap) @(negedge clk);
    m = e;
    item_valid = 1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    item_valid = 0;
  endtask

  function automatic logic signed [15:0] rand_entry(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 15)) - 16'sd8;
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom_range(0, 1023)) - 16'sd512;
    endcase
  endfunction

  // directed: zero, identity, extremes, singular rows, overflow, tiny entries
  task automatic directed_part();
    logic signed [15:0] e [9];
    for (int k = 0; k < 14; k++) begin
      for (int i = 0; i < 9; i++) e[i] = 0;
      case (k)
        0: ;
        1: begin e[0] = 256; e[4] = 256; e[8] = 256; end
        2: for (int i = 0; i < 9; i++) e[i] = 16'sh7FFF;
        3: for (int i = 0; i < 9; i++) e[i] = 16'sh8000;
        4: begin e[0] = 16'sh8000; e[4] = 16'sh8000; e[8] = 16'sh8000; end
        5: begin e[0] = 16'sh7FFF; e[4] = 16'sh7FFF; e[8] = 16'sh7FFF; end
        6: begin e[0] = 1; e[4] = 1; e[8] = 1; end
        7: begin e[0] = -1; e[4] = 1; e[8] = 1; e[1] = 16'sh7FFF; end
        8: begin e[0] = 1; e[1] = 2; e[2] = 3; e[3] = 2; e[4] = 4; e[5] = 6;
                 e[6] = 7; e[7] = 8; e[8] = 9; end
        9: begin e[2] = 256; e[4] = -256; e[6] = 256; end
        10: for (int i = 0; i < 9; i++) e[i] = (i % 2) ? 16'sh8000 : 16'sh7FFF;
        11: begin e[0] = 16'sh8000; e[1] = 16'sh7FFF; e[3] = 16'sh7FFF;
                  e[4] = 16'sh8000; e[8] = 16'sh7FFF; end
        12: begin e[0] = 16'sh5555; e[4] = -16'sh2AAA; e[8] = 16'sh0101;
                  e[5] = 16'sh7F00; end
        default: begin e[0] = 3; e[1] = 1; e[3] = 1; e[4] = 3; e[8] = -1; end
      endcase
      send_matrix(e, $urandom_range(0, 3));
    end
  endtask

  initial begin
    logic signed [15:0] e [9];
    int mode, r;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    directed_part();
    for (int n = 0; n < 1950; n++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) e[i] = rand_entry(mode);
      if ($urandom_range(0, 9) == 0) begin
        // singular by repeated row
        r = $urandom_range(0, 2);
        for (int j = 0; j < 3; j++) e[((r + 1) % 3) * 3 + j] = e[r * 3 + j];
      end
      if (n == 400) begin
        hold_out = 1;
        @(negedge clk);
      end
      if (n == 1000) begin
        while (pending != 0) @(negedge clk);
      end
      send_matrix(e, (n % 300 < 60) ? 0 : $urandom_range(0, 11));
    end
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_out) begin
        res_ready = 0;
        repeat (300) @(negedge clk);
        hold_out = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (w != 0) begin
        res_ready = 0;
        repeat (w) @(negedge clk);
      end
      res_ready = 1;
      do @(posedge clk); while (!res_valid);
      @(negedge clk);
    end
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
sv/mi3_pkg.sv
sv/mi3_front.sv
sv/mi3_div_step.sv
sv/mi3_sat.sv
sv/matrix3x3_inverse.sv
sim/mi3_checker.sv
sim/testbench.sv
